// ===== hw/rtl/smrp_pkg.sv =====
// Shared types and constants of the shutter motor relay positioner.
// Used by the front, the queue, the back and the top level.
`timescale 1ns / 1ps
package smrp_pkg;

   localparam int TICK_W   = 32;
   localparam int TRAVEL_W = 16;
   localparam int VALUE_W  = 16;
   localparam int DQ_W     = 10;

   typedef logic signed [9:0] pos_type;
   localparam pos_type POS_MAX     = 10'sd256;
   localparam pos_type POS_UP      = 10'sd0;
   localparam pos_type POS_UNKNOWN = -10'sd1;

   localparam logic [DQ_W-1:0] DQ_MAX     = 10'd512;
   localparam logic [8:0]      END_FACTOR = 9'd312;

   typedef logic [2:0] opcode_type;
   localparam opcode_type OP_TICK   = 3'd0;
   localparam opcode_type OP_UP     = 3'd1;
   localparam opcode_type OP_DOWN   = 3'd2;
   localparam opcode_type OP_STOP   = 3'd3;
   localparam opcode_type OP_SETPOS = 3'd4;
   localparam opcode_type OP_QUERY  = 3'd5;

   localparam logic CSR_TRAVEL_FIRST  = 1'b0;
   localparam logic CSR_TRAVEL_SECOND = 1'b1;

   typedef enum logic [1:0] {
      DIR_STOP = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd2
   } dir_type;

   typedef enum logic [1:0] {
      TK_NONE = 2'd0,
      TK_MOVE = 2'd1,
      TK_STOP = 2'd2
   } tkind_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_RANGE   = 2'd1,
      ST_UNKNOWN = 2'd2
   } status_type;

   typedef struct packed {
      opcode_type         op;
      logic               motor;
      logic [VALUE_W-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// ===== hw/rtl/smrp_front.sv =====
// Front end: takes requests, drops unused opcodes and absent motors,
// and hands decoded commands to the queue. Depends on smrp_pkg.
`timescale 1ns / 1ps
module smrp_front #(
   parameter int MOTORS = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  smrp_pkg::opcode_type      req_opcode,
   input  logic                      req_motor,
   input  logic [15:0]               req_position_value,
   input  smrp_pkg::qstat_type       q_stat,
   output logic                      push,
   output smrp_pkg::cmd_type         push_cmd
);
   import smrp_pkg::*;

   logic    vld_ff, vld_in;
   cmd_type cmd_ff, cmd_in;
   logic    accept, keep;

   // classify: ticks always count, commands need a known opcode and motor
   always_comb begin
      keep = (req_opcode == OP_TICK) ||
             ((req_opcode <= OP_QUERY) && (int'(req_motor) < MOTORS));
   end

   assign req_stall = vld_ff && q_stat.full;
   assign accept    = req_valid && !req_stall;
   assign push      = vld_ff && !q_stat.full;
   assign push_cmd  = cmd_ff;

   // hold one decoded request until the queue takes it
   always_comb begin
      vld_in = accept ? keep : (vld_ff && !push);
      cmd_in = cmd_ff;
      if (accept) begin
         cmd_in.op    = req_opcode;
         cmd_in.motor = req_motor;
         cmd_in.value = req_position_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

endmodule

// ===== hw/rtl/smrp_queue.sv =====
// Two-entry command queue between front end and back end.
// Depends on smrp_pkg.
`timescale 1ns / 1ps
module smrp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  smrp_pkg::cmd_type    push_cmd,
   input  logic                 pop,
   output smrp_pkg::cmd_type    head_cmd,
   output smrp_pkg::qstat_type  q_stat
);
   import smrp_pkg::*;

   cmd_type    ent_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign q_stat.full  = (cnt_ff == 2'd2);
   assign q_stat.empty = (cnt_ff == 2'd0);
   assign head_cmd     = ent_ff[rd_ff];

   // advance pointers and count
   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hw/rtl/smrp_back.sv =====
// Back end: per-motor state, position estimate divider, relay sequencing
// and the result register. Depends on smrp_pkg.
`timescale 1ns / 1ps
module smrp_back #(
   parameter int MOTORS          = 2,
   parameter int RELAY_GAP_TICKS = 250
) (
   input  logic                 clock,
   input  logic                 reset,
   input  smrp_pkg::qstat_type  q_stat,
   input  smrp_pkg::cmd_type    head_cmd,
   output logic                 pop,
   input  logic [15:0]          travel_first,
   input  logic [15:0]          travel_second,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_motor_id,
   output logic                 rsp_switch_relay,
   output logic                 rsp_direction_relay,
   output logic signed [9:0]    rsp_current_position,
   output logic signed [9:0]    rsp_target_position,
   output logic [1:0]           rsp_status,
   output logic                 rsp_last
);
   import smrp_pkg::*;

   localparam logic [TICK_W-1:0] GAP = TICK_W'(RELAY_GAP_TICKS);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_TSCAN = 8'b0000_0010,
      S_DINIT = 8'b0000_0100,
      S_DIV   = 8'b0000_1000,
      S_EVAL  = 8'b0001_0000,
      S_SCALE = 8'b0010_0000,
      S_APPLY = 8'b0100_0000,
      S_EMIT  = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic sw;
      logic dd;
      logic arm_stop;
      logic arm_move;
   } drive_type;

   function automatic logic ready_of(dir_type d, logic sw, logic dd);
      logic r;
      unique case (d)
         DIR_DOWN: r = sw && dd;
         DIR_UP:   r = sw && !dd;
         default:  r = !sw && !dd;
      endcase
      return r;
   endfunction

   function automatic drive_type drive_of(dir_type d, logic sw, logic dd);
      drive_type o;
      o = '{sw: sw, dd: dd, arm_stop: 1'b0, arm_move: 1'b0};
      if (d == DIR_STOP) begin
         if (sw) begin
            o.sw       = 1'b0;
            o.arm_move = 1'b1;
         end else begin
            o.dd = 1'b0;
         end
      end else if (dd == (d == DIR_DOWN)) begin
         o.sw       = 1'b1;
         o.arm_stop = 1'b1;
      end else begin
         if (sw) begin
            o.sw = 1'b0;
         end else begin
            o.dd = (d == DIR_DOWN);
         end
         o.arm_move = 1'b1;
      end
      return o;
   endfunction

   function automatic pos_type pos_of(pos_type k, dir_type d, logic [DQ_W-1:0] dq);
      logic signed [11:0] ks;
      logic signed [11:0] ds;
      logic signed [11:0] p;
      ks = {{2{k[9]}}, k};
      ds = $signed({2'b00, dq});
      p  = (d == DIR_UP) ? (ks - ds) : (ks + ds);
      if (p < 12'sd0) begin
         p = 12'sd0;
      end
      if (p > 12'sd256) begin
         p = 12'sd256;
      end
      if (k < 10'sd0) begin
         return POS_UNKNOWN;
      end
      if (d == DIR_STOP) begin
         return k;
      end
      return pos_type'(p[9:0]);
   endfunction

   // control and sequencing registers
   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic               mot_ff, mot_in;
   tkind_type          tkact_ff, tkact_in;
   logic               pend_ff, pend_in;
   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic [3:0]         cnt_ff, cnt_in;

   // divider
   logic [15:0]        rem_ff, rem_in;
   logic [9:0]         nlo_ff, nlo_in;
   logic [9:0]         q_ff, q_in;
   logic               sat_ff, sat_in;
   logic [DQ_W-1:0]    dq_ff, dq_in;

   // evaluated request
   pos_type            eknown_ff, eknown_in;
   pos_type            ecur_ff, ecur_in;
   pos_type            r_ff, r_in;
   logic               go_ff, go_in;
   logic               rstop_ff, rstop_in;
   logic               noop_ff, noop_in;
   dir_type            want_ff, want_in;
   logic [8:0]         span_ff, span_in;
   status_type         status_ff, status_in;
   logic [15:0]        delay_ff, delay_in;
   logic [16:0]        endd_ff, endd_in;
   logic               started_ff, started_in;

   // per-motor state
   pos_type            known_ff    [MOTORS];
   pos_type            reqpos_ff   [MOTORS];
   logic [TICK_W-1:0]  start_ff    [MOTORS];
   dir_type            dir_ff      [MOTORS];
   logic [TICK_W-1:0]  deadline_ff [MOTORS];
   tkind_type          tkind_ff    [MOTORS];
   logic               sw_ff       [MOTORS];
   logic               dd_ff       [MOTORS];

   // result register
   logic               rv_ff, rv_in;
   logic               rmot_ff, rsw_ff, rdd_ff, rlast_ff;
   pos_type            rcur_ff, rtgt_ff;
   status_type         rst_ff;

   // working signals
   logic [MOTORS-1:0]  fire;
   logic               fire_hi;
   logic [TICK_W-1:0]  since;
   logic [TRAVEL_W-1:0] t_cur, t_eff;
   logic [TICK_W-1:0]  dt;
   logic [40:0]        num;
   logic [16:0]        trial;
   logic               ge;
   logic               is_timer;
   pos_type            m_known, m_req, kadj, cur;
   dir_type            m_dir;
   logic signed [10:0] diff;
   logic [24:0]        sprod, eprod;
   logic [25:0]        ssum;
   tkind_type          a_kind;
   pos_type            a_known, a_req;
   logic [TICK_W-1:0]  a_start, a_dead;
   dir_type            a_dir;
   logic               a_sw, a_dd, a_started, a_end;
   drive_type          drv;
   pos_type            pcur, ptgt;
   logic               load;

   // timers that expire at the current tick
   always_comb begin
      since = '0;
      for (int m = 0; m < MOTORS; m++) begin
         since   = tick_ff - deadline_ff[m];
         fire[m] = (tkind_ff[m] != TK_NONE) && !since[TICK_W-1];
      end
      fire_hi = (MOTORS > 1) ? fire[MOTORS-1] : 1'b0;
   end

   assign t_cur    = mot_ff ? travel_second : travel_first;
   assign t_eff    = (t_cur == '0) ? TRAVEL_W'(1) : t_cur;
   assign is_timer = (cmd_ff.op == OP_TICK);
   assign m_known  = known_ff[mot_ff];
   assign m_req    = reqpos_ff[mot_ff];
   assign m_dir    = dir_ff[mot_ff];

   // position divider: setup and one quotient bit per step
   always_comb begin
      dt    = tick_ff - start_ff[mot_ff];
      num   = {1'b0, dt, 8'b0} + 41'(t_eff >> 1);
      trial = {rem_ff, nlo_ff[9]};
      ge    = (trial >= {1'b0, t_eff});
   end

   // evaluate the request against the estimate
   always_comb begin
      kadj = m_known;
      if (is_timer && (tkact_ff == TK_STOP) && (m_known == POS_UNKNOWN) &&
          ((m_req == POS_UP) || (m_req == POS_MAX))) begin
         kadj = m_req;
      end
      cur       = pos_of(kadj, m_dir, dq_ff);
      r_in      = POS_UNKNOWN;
      go_in     = 1'b0;
      status_in = ST_OK;
      if (is_timer) begin
         r_in  = (tkact_ff == TK_MOVE) ? m_req : POS_UNKNOWN;
         go_in = 1'b1;
      end else begin
         unique case (cmd_ff.op)
            OP_UP: begin
               r_in  = POS_UP;
               go_in = (cur != POS_UP);
            end
            OP_DOWN: begin
               r_in  = POS_MAX;
               go_in = (cur != POS_MAX);
            end
            OP_STOP: begin
               go_in = 1'b1;
            end
            OP_SETPOS: begin
               if (cmd_ff.value > 16'd256) begin
                  status_in = ST_RANGE;
               end else if ((cur == POS_UNKNOWN) && (cmd_ff.value != 16'd0) &&
                            (cmd_ff.value != 16'd256)) begin
                  status_in = ST_UNKNOWN;
               end else begin
                  r_in  = pos_type'(cmd_ff.value[9:0]);
                  go_in = (cur != pos_type'(cmd_ff.value[9:0]));
               end
            end
            default: begin
               go_in = 1'b0;
            end
         endcase
      end
      rstop_in = (r_in == POS_UNKNOWN);
      noop_in  = 1'b0;
      want_in  = DIR_STOP;
      span_in  = 9'd0;
      diff     = 11'(r_in) - 11'(cur);
      if (cur == POS_UNKNOWN) begin
         span_in = 9'd256;
         if (r_in == POS_UP) begin
            want_in = DIR_UP;
         end else if (r_in == POS_MAX) begin
            want_in = DIR_DOWN;
         end else begin
            noop_in = 1'b1;
         end
      end else if (cur < r_in) begin
         want_in = DIR_DOWN;
         span_in = diff[8:0];
      end else if (cur > r_in) begin
         want_in = DIR_UP;
         span_in = 9'(-diff);
      end
      eknown_in = kadj;
      ecur_in   = cur;
   end

   // scale span and end moves into tick delays
   always_comb begin
      sprod    = span_ff * t_eff;
      ssum     = {1'b0, sprod} + 26'd128;
      delay_in = ssum[23:8];
      eprod    = t_eff * END_FACTOR;
      endd_in  = eprod[24:8];
   end

   // carry out the move on the addressed motor
   always_comb begin
      a_kind    = is_timer ? TK_NONE : tkind_ff[mot_ff];
      a_known   = eknown_ff;
      a_req     = m_req;
      a_start   = start_ff[mot_ff];
      a_dir     = m_dir;
      a_sw      = sw_ff[mot_ff];
      a_dd      = dd_ff[mot_ff];
      a_dead    = deadline_ff[mot_ff];
      a_started = 1'b0;
      drv       = '{sw: a_sw, dd: a_dd, arm_stop: 1'b0, arm_move: 1'b0};
      if (go_ff) begin
         a_req = r_ff;
         if (rstop_ff) begin
            a_known   = ecur_ff;
            a_start   = tick_ff;
            a_started = 1'b1;
            a_dir     = DIR_STOP;
            drv       = drive_of(DIR_STOP, a_sw, a_dd);
         end else if (!noop_ff) begin
            if (m_dir == want_ff) begin
               if (ready_of(m_dir, a_sw, a_dd)) begin
                  drv.arm_stop = 1'b1;
               end else if (a_kind != TK_MOVE) begin
                  drv = drive_of(m_dir, a_sw, a_dd);
                  if (ready_of(m_dir, drv.sw, drv.dd)) begin
                     a_start   = tick_ff;
                     a_started = 1'b1;
                  end
               end
            end else begin
               a_kind    = TK_NONE;
               a_known   = ecur_ff;
               a_start   = tick_ff;
               a_started = 1'b1;
               a_dir     = want_ff;
               drv       = drive_of(want_ff, a_sw, a_dd);
            end
         end
      end
      a_sw  = drv.sw;
      a_dd  = drv.dd;
      a_end = (a_req == POS_UP) || (a_req == POS_MAX);
      if (drv.arm_stop) begin
         a_dead    = tick_ff + (a_end ? TICK_W'(endd_ff) : TICK_W'(delay_ff));
         a_kind    = TK_STOP;
         a_start   = tick_ff;
         a_started = 1'b1;
      end
      if (drv.arm_move) begin
         a_dead = tick_ff + GAP;
         a_kind = TK_MOVE;
      end
      started_in = a_started;
   end

   // result from the state left behind
   always_comb begin
      pcur  = pos_of(known_ff[mot_ff], m_dir, started_ff ? '0 : dq_ff);
      ptgt  = (m_req == POS_UNKNOWN) ? pcur : m_req;
      load  = (state_ff == S_EMIT) && (!rv_ff || !rsp_stall);
      rv_in = load || (rv_ff && rsp_stall);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      mot_in   = mot_ff;
      tkact_in = tkact_ff;
      pend_in  = pend_ff;
      tick_in  = tick_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      nlo_in   = nlo_ff;
      q_in     = q_ff;
      sat_in   = sat_ff;
      dq_in    = dq_ff;
      pop      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_stat.empty) begin
               pop    = 1'b1;
               cmd_in = head_cmd;
               mot_in = head_cmd.motor;
               if (head_cmd.op == OP_TICK) begin
                  tick_in  = tick_ff + TICK_W'(1);
                  state_in = S_TSCAN;
               end else begin
                  state_in = S_DINIT;
               end
            end
         end
         S_TSCAN: begin
            if (fire[0]) begin
               mot_in   = 1'b0;
               tkact_in = tkind_ff[0];
               pend_in  = fire_hi;
               state_in = S_DINIT;
            end else if (fire_hi) begin
               mot_in   = 1'b1;
               tkact_in = tkind_ff[MOTORS-1];
               pend_in  = 1'b0;
               state_in = S_DINIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DINIT: begin
            sat_in   = (num[40:10] >= 31'(t_eff));
            rem_in   = num[25:10];
            nlo_in   = num[9:0];
            q_in     = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in = ge ? 16'(trial - {1'b0, t_eff}) : trial[15:0];
            q_in   = {q_ff[8:0], ge};
            nlo_in = {nlo_ff[8:0], 1'b0};
            cnt_in = cnt_ff + 4'd1;
            // clamp the finished quotient so the estimate is ready for evaluation
            if (cnt_ff == 4'd9) begin
               dq_in    = (sat_ff || (q_in > DQ_MAX)) ? DQ_MAX : q_in;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            state_in = S_SCALE;
         end
         S_SCALE: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (load) begin
               if (is_timer && !mot_ff && pend_ff) begin
                  mot_in   = 1'b1;
                  tkact_in = tkind_ff[MOTORS-1];
                  pend_in  = 1'b0;
                  state_in = S_DINIT;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         tick_ff  <= '0;
         pend_ff  <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         tick_ff  <= tick_in;
         pend_ff  <= pend_in;
         rv_ff    <= rv_in;
      end
   end

   // working payload registers
   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      mot_ff   <= mot_in;
      tkact_ff <= tkact_in;
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      nlo_ff   <= nlo_in;
      q_ff     <= q_in;
      sat_ff   <= sat_in;
      dq_ff    <= dq_in;
      if (state_ff == S_EVAL) begin
         eknown_ff <= eknown_in;
         ecur_ff   <= ecur_in;
         r_ff      <= r_in;
         go_ff     <= go_in;
         rstop_ff  <= rstop_in;
         noop_ff   <= noop_in;
         want_ff   <= want_in;
         span_ff   <= span_in;
         status_ff <= status_in;
      end
      if (state_ff == S_SCALE) begin
         delay_ff <= delay_in;
         endd_ff  <= endd_in;
      end
      if (state_ff == S_APPLY) begin
         started_ff <= started_in;
      end
      if (load) begin
         rmot_ff  <= mot_ff;
         rsw_ff   <= sw_ff[mot_ff];
         rdd_ff   <= dd_ff[mot_ff];
         rcur_ff  <= pcur;
         rtgt_ff  <= ptgt;
         rst_ff   <= status_ff;
         rlast_ff <= !(is_timer && !mot_ff && pend_ff);
      end
   end

   // per-motor state, written once per handled motor
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int m = 0; m < MOTORS; m++) begin
            known_ff[m]    <= POS_UNKNOWN;
            reqpos_ff[m]   <= POS_UP;
            start_ff[m]    <= '0;
            dir_ff[m]      <= DIR_STOP;
            deadline_ff[m] <= '0;
            tkind_ff[m]    <= TK_NONE;
            sw_ff[m]       <= 1'b0;
            dd_ff[m]       <= 1'b0;
         end
      end else if (state_ff == S_APPLY) begin
         known_ff[mot_ff]    <= a_known;
         reqpos_ff[mot_ff]   <= a_req;
         start_ff[mot_ff]    <= a_start;
         dir_ff[mot_ff]      <= a_dir;
         deadline_ff[mot_ff] <= a_dead;
         tkind_ff[mot_ff]    <= a_kind;
         sw_ff[mot_ff]       <= a_sw;
         dd_ff[mot_ff]       <= a_dd;
      end
   end

   assign rsp_valid            = rv_ff;
   assign rsp_motor_id         = rmot_ff;
   assign rsp_switch_relay     = rsw_ff;
   assign rsp_direction_relay  = rdd_ff;
   assign rsp_current_position = rcur_ff;
   assign rsp_target_position  = rtgt_ff;
   assign rsp_status           = rst_ff;
   assign rsp_last             = rlast_ff;

endmodule

// ===== hw/rtl/shutter_motor_relay_positioner.sv =====
// Top level of the shutter motor relay positioner: travel time registers,
// front end, command queue and back end. Depends on smrp_pkg.
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  req     | req_valid/req_stall | opcode, motor, position_value
//  rsp     | rsp_valid/rsp_stall | motor_id, relays, positions, status, last
//  csr     | csr_valid/csr_ready | csr_index, csr_data (travel times)
//
// Most back-end time on a command goes to the 10-step position divider; a tick
// that fires both motors runs the divider once for each motor.
// A request passes the front register and the queue before the back end.
// Reset is synchronous: positions unknown, relays off, no timers, tick zero.
// The queue lets the front take requests while the result register is stalled.
`timescale 1ns / 1ps
module shutter_motor_relay_positioner #(
   parameter int MOTORS          = 2,
   parameter int RELAY_GAP_TICKS = 250
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [2:0]           req_opcode,
   input  logic                 req_motor,
   input  logic [15:0]          req_position_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_motor_id,
   output logic                 rsp_switch_relay,
   output logic                 rsp_direction_relay,
   output logic signed [9:0]    rsp_current_position,
   output logic signed [9:0]    rsp_target_position,
   output logic [1:0]           rsp_status,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_index,
   input  logic [15:0]          csr_data
);
   import smrp_pkg::*;

   logic [TRAVEL_W-1:0] travel_first_ff, travel_first_in;
   logic [TRAVEL_W-1:0] travel_second_ff, travel_second_in;
   qstat_type           q_stat;
   cmd_type             push_cmd, head_cmd;
   logic                push, pop;

   assign csr_ready = 1'b1;

   // decode register writes
   always_comb begin
      travel_first_in  = travel_first_ff;
      travel_second_in = travel_second_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TRAVEL_FIRST:  travel_first_in  = csr_data;
            CSR_TRAVEL_SECOND: travel_second_in = csr_data;
            default:           travel_first_in  = travel_first_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         travel_first_ff  <= 16'd26000;
         travel_second_ff <= 16'd26000;
      end else begin
         travel_first_ff  <= travel_first_in;
         travel_second_ff <= travel_second_in;
      end
   end

   smrp_front #(
      .MOTORS (MOTORS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_motor          (req_motor),
      .req_position_value (req_position_value),
      .q_stat             (q_stat),
      .push               (push),
      .push_cmd           (push_cmd)
   );

   smrp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_stat   (q_stat)
   );

   smrp_back #(
      .MOTORS          (MOTORS),
      .RELAY_GAP_TICKS (RELAY_GAP_TICKS)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .q_stat               (q_stat),
      .head_cmd             (head_cmd),
      .pop                  (pop),
      .travel_first         (travel_first_ff),
      .travel_second        (travel_second_ff),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_motor_id         (rsp_motor_id),
      .rsp_switch_relay     (rsp_switch_relay),
      .rsp_direction_relay  (rsp_direction_relay),
      .rsp_current_position (rsp_current_position),
      .rsp_target_position  (rsp_target_position),
      .rsp_status           (rsp_status),
      .rsp_last             (rsp_last)
   );

endmodule

// ===== test/shutter_motor_relay_positioner_tb.sv =====
// Self-checking testbench of the shutter motor relay positioner: random
// and directed requests, a local predictor of relays, timers and positions.
// Depends on smrp_pkg and the shutter_motor_relay_positioner top level.
`timescale 1ns / 1ps
module shutter_motor_relay_positioner_tb;
   import smrp_pkg::*;

   localparam int GAP_TICKS = 250;
   localparam int IDLE_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 300;

   typedef struct {
      opcode_type         op;
      logic               motor;
      logic [VALUE_W-1:0] value;
   } request_type;

   typedef struct {
      logic       motor_id;
      logic       switch_relay;
      logic       direction_relay;
      pos_type    cur;
      pos_type    tgt;
      status_type status;
      logic       last;
   } relay_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_opcode = '0;
   logic req_motor = 1'b0;
   logic [15:0] req_position_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_motor_id, rsp_switch_relay, rsp_direction_relay, rsp_last;
   logic signed [9:0] rsp_current_position, rsp_target_position;
   logic [1:0] rsp_status;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = 1'b0;
   logic [15:0] csr_data = '0;

   shutter_motor_relay_positioner u_top (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow state of both motors
   int unsigned travel_cfg [2];
   int unsigned tick_now;
   int          known_pos [2];
   int          wanted_pos [2];
   int unsigned move_start [2];
   dir_type     heading [2];
   int unsigned deadline [2];
   tkind_type   timer_sel [2];
   bit          power_on [2];
   bit          going_down [2];

   request_type      pending_q [$];
   relay_report_type report_q [$];
   int errors, results_seen, requests_sent, timer_events, idle_cycles;
   int cycles_since_req;

   function automatic int unsigned travel_of(int m);
      return travel_cfg[m] == 0 ? 1 : travel_cfg[m];
   endfunction

   function automatic int position_now(int m);
      longint unsigned t, dt, d;
      int p;
      if (known_pos[m] < 0) return -1;
      if (heading[m] == DIR_STOP) return known_pos[m];
      t = travel_of(m);
      dt = longint'(tick_now - move_start[m]);
      d = (256 * dt + t / 2) / t;
      if (d > 512) d = 512;
      p = heading[m] == DIR_UP ? known_pos[m] - int'(d) : known_pos[m] + int'(d);
      if (p < 0) p = 0;
      if (p > 256) p = 256;
      return p;
   endfunction

   function automatic bit relays_settled(int m);
      if (heading[m] == DIR_DOWN) return power_on[m] && going_down[m];
      if (heading[m] == DIR_UP) return power_on[m] && !going_down[m];
      return !power_on[m] && !going_down[m];
   endfunction

   function automatic void arm_stop(int m, int unsigned delay);
      if (wanted_pos[m] == 0 || wanted_pos[m] == 256) delay = travel_of(m) * 312 / 256;
      deadline[m] = tick_now + delay;
      timer_sel[m] = TK_STOP;
      move_start[m] = tick_now;
   endfunction

   function automatic void arm_gap(int m);
      deadline[m] = tick_now + GAP_TICKS;
      timer_sel[m] = TK_MOVE;
   endfunction

   function automatic void turn(int m, dir_type d);
      known_pos[m] = position_now(m);
      move_start[m] = tick_now;
      heading[m] = d;
   endfunction

   function automatic void step_relays(int m, int unsigned delay);
      if (heading[m] == DIR_STOP) begin
         if (power_on[m]) begin
            power_on[m] = 0;
            arm_gap(m);
         end else begin
            going_down[m] = 0;
         end
         return;
      end
      if (going_down[m] == (heading[m] == DIR_DOWN)) begin
         power_on[m] = 1;
         arm_stop(m, delay);
      end else begin
         if (power_on[m]) power_on[m] = 0;
         else going_down[m] = (heading[m] == DIR_DOWN);
         arm_gap(m);
      end
   endfunction

   function automatic void pursue(int m);
      int cur, span;
      dir_type want;
      int unsigned delay;
      if (wanted_pos[m] == -1) begin
         turn(m, DIR_STOP);
         step_relays(m, 0);
         return;
      end
      cur = position_now(m);
      if (cur == -1) begin
         if (wanted_pos[m] == 0) want = DIR_UP;
         else if (wanted_pos[m] == 256) want = DIR_DOWN;
         else return;
         span = 256;
      end else if (cur < wanted_pos[m]) begin
         want = DIR_DOWN;
         span = wanted_pos[m] - cur;
      end else if (cur > wanted_pos[m]) begin
         want = DIR_UP;
         span = cur - wanted_pos[m];
      end else begin
         want = DIR_STOP;
         span = 0;
      end
      delay = (span * travel_of(m) + 128) / 256;
      if (heading[m] == want) begin
         if (relays_settled(m)) begin
            arm_stop(m, delay);
         end else if (timer_sel[m] != TK_MOVE) begin
            step_relays(m, delay);
            if (relays_settled(m)) move_start[m] = tick_now;
         end
      end else begin
         timer_sel[m] = TK_NONE;
         turn(m, want);
         step_relays(m, delay);
      end
   endfunction

   function automatic void head_for(int m, int pos);
      if (position_now(m) != pos || pos == -1) begin
         wanted_pos[m] = pos;
         pursue(m);
      end
   endfunction

   function automatic void report(int m, status_type st);
      relay_report_type r;
      int tgt;
      tgt = wanted_pos[m] == -1 ? position_now(m) : wanted_pos[m];
      r.motor_id = m[0];
      r.switch_relay = power_on[m];
      r.direction_relay = going_down[m];
      r.cur = pos_type'(position_now(m));
      r.tgt = pos_type'(tgt);
      r.status = st;
      r.last = 1'b0;
      report_q.push_back(r);
   endfunction

   function automatic void predict_request(request_type q);
      int m, n;
      tkind_type kind;
      status_type st;
      m = q.motor;
      n = 0;
      st = ST_OK;
      if (q.op == OP_TICK) begin
         tick_now++;
         for (int i = 0; i < 2; i++) begin
            kind = timer_sel[i];
            if (kind == TK_NONE) continue;
            if (int'(tick_now - deadline[i]) < 0) continue;
            timer_sel[i] = TK_NONE;
            if (kind == TK_MOVE) begin
               pursue(i);
            end else begin
               if (known_pos[i] == -1 && (wanted_pos[i] == 0 || wanted_pos[i] == 256))
                  known_pos[i] = wanted_pos[i];
               head_for(i, -1);
            end
            report(i, ST_OK);
            n++;
            timer_events++;
         end
         if (n > 0) report_q[$].last = 1'b1;
         return;
      end
      if (q.op > OP_QUERY) return;
      case (q.op)
         OP_UP:   head_for(m, 0);
         OP_DOWN: head_for(m, 256);
         OP_STOP: head_for(m, -1);
         OP_SETPOS: begin
            if (q.value > 256) st = ST_RANGE;
            else if (position_now(m) == -1 && q.value != 0 && q.value != 256) st = ST_UNKNOWN;
            else head_for(m, int'(q.value));
         end
         default: ;
      endcase
      report(m, st);
      report_q[$].last = 1'b1;
   endfunction

   // feed requests from the pending queue, with random gaps and burst stretches
   int gap_left;
   bit burst_mode;
   always @(posedge clock) begin
      request_type nxt;
      logic next_valid;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
         cycles_since_req <= 0;
      end else begin
         next_valid = req_valid;
         if (req_valid && !req_stall) begin
            nxt.op = req_opcode;
            nxt.motor = req_motor;
            nxt.value = req_position_value;
            predict_request(nxt);
            requests_sent++;
            cycles_since_req <= 0;
            if ($urandom_range(0, 99) == 0) burst_mode = !burst_mode;
         end else begin
            cycles_since_req <= cycles_since_req + 1;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               next_valid = 1'b0;
            end else if (pending_q.size() > 0) begin
               nxt = pending_q.pop_front();
               req_opcode <= nxt.op;
               req_motor <= nxt.motor;
               req_position_value <= nxt.value;
               next_valid = 1'b1;
               if (burst_mode || $urandom_range(0, 9) < 6) gap_left <= 0;
               else if ($urandom_range(0, 9) < 9) gap_left <= $urandom_range(1, 3);
               else gap_left <= $urandom_range(10, 40);
            end else begin
               next_valid = 1'b0;
            end
         end
         req_valid <= next_valid;
      end
   end

   // check each result against the oldest expectation, stall at random
   always @(posedge clock) begin
      relay_report_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (report_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result: motor %0d", rsp_motor_id);
            end else begin
               e = report_q.pop_front();
               if (rsp_motor_id !== e.motor_id || rsp_switch_relay !== e.switch_relay ||
                   rsp_direction_relay !== e.direction_relay ||
                   rsp_current_position !== e.cur || rsp_target_position !== e.tgt ||
                   rsp_status !== e.status || rsp_last !== e.last) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch exp m%0d sw%0d dn%0d cur%0d tgt%0d st%0d l%0d, %s",
                        e.motor_id, e.switch_relay, e.direction_relay, e.cur, e.tgt,
                        e.status, e.last,
                        $sformatf("got m%0d sw%0d dn%0d cur%0d tgt%0d st%0d l%0d",
                           rsp_motor_id, rsp_switch_relay, rsp_direction_relay,
                           rsp_current_position, rsp_target_position, rsp_status,
                           rsp_last));
               end
            end
         end
         if (burst_mode || $urandom_range(0, 9) < 6) rsp_stall <= 1'b0;
         else if ($urandom_range(0, 19) < 19) rsp_stall <= 1'b1;
         else rsp_stall <= 1'($urandom_range(0, 1));
      end
   end

   // end the run when nothing has been accepted for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout with %0d results outstanding", report_q.size());
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic add_request(opcode_type op, logic m, logic [15:0] v);
      request_type q;
      q.op = op;
      q.motor = m;
      q.value = v;
      pending_q.push_back(q);
   endtask

   task automatic drain();
      while (pending_q.size() > 0 || req_valid || report_q.size() > 0 ||
             cycles_since_req < SETTLE_CYCLES)
         @(posedge clock);
   endtask

   task automatic write_travel(logic idx, logic [15:0] t);
      csr_index <= idx;
      csr_data <= t;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      travel_cfg[idx] = 32'(t);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // one command then a run of ticks, mostly sensible commands
   task automatic add_random_phase(int count);
      int k, r, runlen;
      logic [15:0] v;
      k = 0;
      while (k < count) begin
         r = $urandom_range(0, 99);
         if (r < 60) v = 16'($urandom_range(0, 256));
         else if (r < 80) v = $urandom_range(0, 1) ? 16'd256 : 16'd0;
         else v = 16'($urandom);
         r = $urandom_range(0, 99);
         if (r < 20) add_request(OP_UP, 1'($urandom), 16'($urandom));
         else if (r < 40) add_request(OP_DOWN, 1'($urandom), 16'($urandom));
         else if (r < 52) add_request(OP_STOP, 1'($urandom), 16'($urandom));
         else if (r < 80) add_request(OP_SETPOS, 1'($urandom), v);
         else if (r < 92) add_request(OP_QUERY, 1'($urandom), 16'($urandom));
         else add_request(opcode_type'($urandom_range(0, 7)), 1'($urandom),
                          16'($urandom));
         runlen = $urandom_range(0, 9) < 7 ? $urandom_range(1, 60) : $urandom_range(100, 400);
         if (runlen > count - k - 1) runlen = count - k - 1;
         for (int j = 0; j < runlen; j++) add_request(OP_TICK, 1'($urandom), 16'($urandom));
         k += runlen + 1;
      end
   endtask

   initial begin
      logic [15:0] t0 [6];
      logic [15:0] t1 [6];
      travel_cfg[0] = 26000;
      travel_cfg[1] = 26000;
      tick_now = 0;
      for (int m = 0; m < 2; m++) begin
         known_pos[m] = -1;
         wanted_pos[m] = 0;
         move_start[m] = 0;
         heading[m] = DIR_STOP;
         deadline[m] = 0;
         timer_sel[m] = TK_NONE;
         power_on[m] = 0;
         going_down[m] = 0;
      end
      burst_mode = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: unknown position, range errors, unused opcodes, relay sequencing
      add_request(OP_QUERY, 1'b0, 16'd0);
      add_request(OP_SETPOS, 1'b0, 16'd100);
      add_request(OP_SETPOS, 1'b1, 16'd257);
      add_request(OP_SETPOS, 1'b1, 16'hFFFF);
      add_request(opcode_type'(6), 1'b0, 16'd0);
      add_request(opcode_type'(7), 1'b1, 16'hFFFF);
      add_request(OP_STOP, 1'b0, 16'd0);
      add_request(OP_UP, 1'b0, 16'd0);
      add_request(OP_DOWN, 1'b1, 16'd0);
      add_request(OP_DOWN, 1'b1, 16'd0);
      add_request(OP_UP, 1'b1, 16'd0);
      add_request(OP_SETPOS, 1'b0, 16'd256);
      add_request(OP_SETPOS, 1'b0, 16'd0);
      add_request(OP_STOP, 1'b1, 16'd0);
      for (int j = 0; j < 10; j++) add_request(OP_TICK, 1'b1, 16'hFFFF);
      add_request(OP_QUERY, 1'b1, 16'hFFFF);
      drain();

      // travel settings, extremes first; each phase drains before the next write
      t0 = '{16'd1, 16'd65535, 16'd300, 16'd40, 16'd0, 16'd0};
      t1 = '{16'd65535, 16'd1, 16'd500, 16'd40, 16'd0, 16'd0};
      t0[4] = 16'($urandom_range(1, 700));
      t1[4] = 16'($urandom_range(1, 700));
      t0[5] = 16'($urandom_range(1, 65535));
      t1[5] = 16'($urandom_range(1, 300));
      for (int p = 0; p < 6; p++) begin
         write_travel(CSR_TRAVEL_FIRST, t0[p]);
         write_travel(CSR_TRAVEL_SECOND, t1[p]);
         add_random_phase(p == 5 ? 45 : 65);
         drain();
      end

      $display("sent %0d requests, checked %0d results, %0d timer firings",
               requests_sent, results_seen, timer_events);
      $display("covered 7 travel settings including 1 and 65535 ticks");
      if (errors == 0 && report_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d results missing", errors, report_q.size());
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
